>>> rtl/rps_pkg.sv
// Range-partition scatter: shared sizes, codes, request/result types and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package rps_pkg;

  localparam int NUM_RANGES    = 16;
  localparam int ROW_ADDR_BITS = 24;

  localparam int IDX_W  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int LOAD_W = $clog2(NUM_RANGES + 1);
  localparam int CNT_W  = 25;
  localparam int VAL_W  = 32;
  localparam int EXP_W  = 24;
  localparam int ADDR_W = 24;
  localparam int RIDX_W = 6;

  // address bits kept: the row address width, cut to the address field
  localparam int ADDR_KEEP = (ROW_ADDR_BITS < ADDR_W) ? ROW_ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    ADDR_W'((33'd1 << ADDR_KEEP) - 33'd1);

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_VALUE  = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2,
    ST_TOTAL    = 2'd3
  } status_t;

  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    func_t                    func;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  lower_bound;
    logic signed [VAL_W-1:0]  upper_bound;
    logic        [EXP_W-1:0]  expected_count;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic        [RIDX_W-1:0] range_index;
    logic        [ADDR_W-1:0] address;
    logic signed [VAL_W-1:0]  placed_value;
    status_t                  status;
    logic                     last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic start_scan;
    logic scan_step;
    logic start_check;
    logic check_step;
    logic flush;
    logic emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic out_free;
    logic last_idx;
    logic none_loaded;
  } stat_t;

endpackage

>>> rtl/rps_if.sv
// Request and result channel interfaces of the range-partition scatter.
// Depends on rps_pkg for field widths.
`timescale 1ns / 1ps

interface rps_in_if;
  import rps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] lower_bound;
  logic signed [VAL_W-1:0] upper_bound;
  logic [EXP_W-1:0]        expected_count;

  modport source (output valid, func, value, lower_bound, upper_bound, expected_count,
                  input ready);
  modport sink   (input valid, func, value, lower_bound, upper_bound, expected_count,
                  output ready);
endinterface

interface rps_out_if;
  import rps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [RIDX_W-1:0]       range_index;
  logic [ADDR_W-1:0]       address;
  logic signed [VAL_W-1:0] placed_value;
  logic [1:0]              status;
  logic                    last;

  modport source (output valid, kind, range_index, address, placed_value, status, last,
                  input ready);
  modport sink   (input valid, kind, range_index, address, placed_value, status, last,
                  output ready);
endinterface

>>> rtl/rps_ctrl.sv
// Range-partition scatter controller: sequences table loads, per-value
// range scans and the end-check scan. Depends on rps_pkg.
`timescale 1ns / 1ps

module rps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rps_pkg::func_t in_func,
  output logic           in_ready,
  input  rps_pkg::stat_t stat,
  output rps_pkg::cmd_t  cmd
);
  import rps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FLUSH  = 5'b00100,
    S_CHECK  = 5'b01000,
    S_STATUS = 5'b10000
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_CLEAR:  cmd.clear = 1'b1;
            FUNC_APPEND: cmd.append = 1'b1;
            FUNC_VALUE: begin
              cmd.start_scan = 1'b1;
              if (!stat.none_loaded) state_next = S_SCAN;
            end
            FUNC_END: begin
              cmd.start_check = 1'b1;
              state_next = stat.none_loaded ? S_STATUS : S_CHECK;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // a new hit pushes the held placement out: wait for the output slot
        if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_step = 1'b1;
          if (stat.last_idx) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.check_step = 1'b1;
        if (stat.last_idx) state_next = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

>>> rtl/rps_dp.sv
// Range-partition scatter datapath: range table, counters, scan compare,
// held placement and output register. Depends on rps_pkg.
`timescale 1ns / 1ps

module rps_dp (
  input  logic               clk,
  input  logic               rst,
  input  rps_pkg::cmd_t      cmd,
  input  rps_pkg::in_item_t  in_item,
  output rps_pkg::stat_t     stat,
  input  logic               out_ready,
  output logic               out_valid,
  output rps_pkg::out_item_t out_item
);
  import rps_pkg::*;

  // range table, valid only below the load count
  logic signed [VAL_W-1:0]  range_low      [NUM_RANGES];
  logic signed [VAL_W-1:0]  range_high     [NUM_RANGES];
  logic        [EXP_W-1:0]  range_expected [NUM_RANGES];
  logic        [ADDR_W-1:0] range_base     [NUM_RANGES];
  logic        [EXP_W-1:0]  range_written  [NUM_RANGES];

  logic [LOAD_W-1:0]       loaded;
  logic [CNT_W-1:0]        running_base;
  logic [CNT_W-1:0]        source_seen;
  logic [CNT_W-1:0]        total_placed;
  logic                    overflow_seen;
  logic                    short_seen;
  logic [IDX_W-1:0]        idx;
  logic signed [VAL_W-1:0] cur_value;
  out_item_t               pend;
  logic                    pend_valid;

  logic signed [VAL_W-1:0] sel_low, sel_high;
  logic [EXP_W-1:0]        sel_exp, sel_written;
  logic [ADDR_W-1:0]       sel_base, place_addr;
  logic                    match, full, hit, table_full, load_out;
  logic [CNT_W:0]          base_sum, seen_sum, placed_sum;

  // entry under the scan pointer
  assign sel_low     = range_low[idx];
  assign sel_high    = range_high[idx];
  assign sel_exp     = range_expected[idx];
  assign sel_base    = range_base[idx];
  assign sel_written = range_written[idx];

  assign match      = (cur_value >= sel_low) && (cur_value <= sel_high);
  assign full       = (sel_written >= sel_exp);
  assign hit        = match && !full;
  assign place_addr = (sel_base + sel_written) & ADDR_MASK;
  assign table_full = (loaded == LOAD_W'(NUM_RANGES));

  // saturating counters
  assign base_sum   = {1'b0, running_base} + (CNT_W + 1)'(in_item.expected_count);
  assign seen_sum   = {1'b0, source_seen} + (CNT_W + 1)'(1);
  assign placed_sum = {1'b0, total_placed} + (CNT_W + 1)'(1);

  always_comb begin
    stat.hit         = hit;
    stat.pend_valid  = pend_valid;
    stat.out_free    = !out_valid || out_ready;
    stat.last_idx    = ((LOAD_W'(idx) + LOAD_W'(1)) == loaded);
    stat.none_loaded = (loaded == '0);
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.append && !table_full) begin
      range_low[loaded[IDX_W-1:0]]      <= in_item.lower_bound;
      range_high[loaded[IDX_W-1:0]]     <= in_item.upper_bound;
      range_expected[loaded[IDX_W-1:0]] <= in_item.expected_count;
      range_base[loaded[IDX_W-1:0]]     <= running_base[ADDR_W-1:0] & ADDR_MASK;
      range_written[loaded[IDX_W-1:0]]  <= '0;
    end else if (cmd.scan_step && hit) begin
      range_written[idx] <= sel_written + EXP_W'(1);
    end
  end

  // counters, flags and scan pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      loaded        <= '0;
      running_base  <= '0;
      source_seen   <= '0;
      total_placed  <= '0;
      overflow_seen <= 1'b0;
      short_seen    <= 1'b0;
      idx           <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (cmd.append && !table_full) begin
        loaded       <= loaded + LOAD_W'(1);
        running_base <= base_sum[CNT_W] ? '1 : base_sum[CNT_W-1:0];
      end
      if (cmd.start_scan) begin
        source_seen <= seen_sum[CNT_W] ? '1 : seen_sum[CNT_W-1:0];
        idx         <= '0;
      end
      if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
        if (match && full) overflow_seen <= 1'b1;
        if (hit) begin
          total_placed <= placed_sum[CNT_W] ? '1 : placed_sum[CNT_W-1:0];
          pend_valid   <= 1'b1;
        end
      end
      if (cmd.start_check) begin
        idx        <= '0;
        short_seen <= 1'b0;
      end
      if (cmd.check_step) begin
        idx <= idx + IDX_W'(1);
        if (sel_written != sel_exp) short_seen <= 1'b1;
      end
      if (cmd.flush) pend_valid <= 1'b0;
    end
  end

  // held placement; its last flag is known only when the scan ends
  always_ff @(posedge clk) begin
    if (cmd.start_scan) cur_value <= in_item.value;
    if (cmd.scan_step && hit) begin
      pend.kind         <= KIND_PLACE;
      pend.range_index  <= RIDX_W'(idx);
      pend.address      <= place_addr;
      pend.placed_value <= cur_value;
      pend.status       <= ST_OK;
      pend.last         <= 1'b0;
    end
  end

  // output register
  assign load_out = (cmd.scan_step && hit && pend_valid) || cmd.flush || cmd.emit_status;

  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (load_out)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      out_item.kind         <= KIND_STATUS;
      out_item.range_index  <= '0;
      out_item.address      <= '0;
      out_item.placed_value <= '0;
      out_item.last         <= 1'b1;
      priority if (overflow_seen)              out_item.status <= ST_OVERFLOW;
      else if (short_seen)                     out_item.status <= ST_SHORT;
      else if (total_placed != source_seen)    out_item.status <= ST_TOTAL;
      else                                     out_item.status <= ST_OK;
    end else if (cmd.flush) begin
      out_item <= '{pend.kind, pend.range_index, pend.address, pend.placed_value,
                    pend.status, 1'b1};
    end else if (load_out) begin
      out_item <= pend;
    end
  end

endmodule

>>> rtl/range_partition_scatter.sv
// Range-partition scatter, top level. Clear and append are each done in the idle state.
// A source value is compared with each loaded range in turn, then the held
// placement is released (no scan is made with no range loaded); this waits
// while results stall.
// An end check runs a status scan over the loaded ranges, then emits the status.
// Reset clears counters, flags and the output valid flag; table contents are
// undefined until appended. Depends on rps_pkg, rps_if, rps_ctrl, rps_dp.
`timescale 1ns / 1ps

module range_partition_scatter (
  input logic       clk,
  input logic       rst,
  rps_in_if.sink    in,
  rps_out_if.source out
);
  import rps_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  cmd_t      cmd;
  stat_t     stat;
  logic      ctrl_ready;
  logic      dp_valid;

  // request unpack
  always_comb begin
    in_item.func           = func_t'(in.func);
    in_item.value          = in.value;
    in_item.lower_bound    = in.lower_bound;
    in_item.upper_bound    = in.upper_bound;
    in_item.expected_count = in.expected_count;
  end

  assign in.ready = ctrl_ready;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_func  (in_item.func),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_ready (out.ready),
    .out_valid (dp_valid),
    .out_item  (out_item)
  );

  // result pack
  assign out.valid        = dp_valid;
  assign out.kind         = out_item.kind;
  assign out.range_index  = out_item.range_index;
  assign out.address      = out_item.address;
  assign out.placed_value = out_item.placed_value;
  assign out.status       = out_item.status;
  assign out.last         = out_item.last;

  // no placement may be held while a new request is taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !stat.pend_valid)
    else $error("held placement while accepting a request");

  // the output register is loaded only when free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush || cmd.emit_status || (cmd.scan_step && stat.hit && stat.pend_valid))
      |-> stat.out_free)
    else $error("output register overwritten");

  // a status result always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.kind == KIND_STATUS) |-> out.last)
    else $error("status result without last");

endmodule
